// ----- hdl/hlfd_pkg.sv -----
// shared types, constants and register indexes for the header/length frame deframer
// no dependencies; used by every module of the block by scoped names

package hlfd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_VALUE  = 2'd0;
    localparam logic [1:0] REG_WANTED_ID     = 2'd1;
    localparam logic [1:0] REG_FILTER_ENABLE = 2'd2;

    // configuration reset values
    localparam logic [7:0] HEADER_VALUE_RST  = 8'h8D;
    localparam logic [7:0] WANTED_ID_RST     = 8'h25;
    localparam logic       FILTER_ENABLE_RST = 1'b1;

    // frame layout: header, length, id, then length+1 more bytes
    localparam logic [8:0] POS_HUNT   = 9'd0;
    localparam logic [8:0] POS_LENGTH = 9'd1;
    localparam logic [8:0] POS_ID     = 9'd2;
    localparam logic [8:0] FRAME_OVERHEAD_M1 = 9'd3;
    localparam logic [8:0] POS_MAX    = 9'd258;

    // results written per transfer at most
    localparam int MAX_PUSH = 3;

    // default output queue depth, a power of two no smaller than eight
    localparam int OUT_DEPTH_DEF = 16;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] wanted_message_id;
        logic       filter_enable;
    } hlfd_cfg_t;

    typedef struct packed {
        logic       last_of_frame;
        logic [8:0] byte_index;
        logic [7:0] frame_byte;
    } hlfd_res_t;

    typedef struct packed {
        logic [1:0]            cnt;
        hlfd_res_t [2:0]       item;
    } hlfd_push_t;

endpackage

// ----- hdl/hlfd_parser.sv -----
// frame parser: tracks frame position and emits up to three results per byte
// depends on hlfd_pkg

module hlfd_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic [7:0]         rx_byte,
    input  hlfd_pkg::hlfd_cfg_t cfg,
    output hlfd_pkg::hlfd_push_t push
);

    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic       passes_reg, passes_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [8:0] last_index;
    logic       is_last;
    logic       pass_now;

    // end of frame compare
    assign last_index = {1'b0, len_reg} + hlfd_pkg::FRAME_OVERHEAD_M1;
    assign is_last    = (pos_reg >= last_index);
    assign pass_now   = !cfg.filter_enable || (rx_byte == cfg.wanted_message_id);

    // per-byte frame step
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        passes_next = passes_reg;
        hdr_next    = hdr_reg;
        push        = '0;
        if (byte_valid)
        begin
            case (pos_reg)
                hlfd_pkg::POS_HUNT:
                begin
                    if (rx_byte == cfg.header_value)
                    begin
                        hdr_next = rx_byte;
                        pos_next = hlfd_pkg::POS_LENGTH;
                    end
                end
                hlfd_pkg::POS_LENGTH:
                begin
                    len_next = rx_byte;
                    pos_next = hlfd_pkg::POS_ID;
                end
                hlfd_pkg::POS_ID:
                begin
                    passes_next = pass_now;
                    if (pass_now)
                    begin
                        push.cnt = 2'd3;
                        push.item[0] = '{last_of_frame: 1'b0, byte_index: 9'd0,
                                         frame_byte: hdr_reg};
                        push.item[1] = '{last_of_frame: 1'b0, byte_index: 9'd1,
                                         frame_byte: len_reg};
                        push.item[2] = '{last_of_frame: 1'b0, byte_index: 9'd2,
                                         frame_byte: rx_byte};
                    end
                    pos_next = pos_reg + 9'd1;
                end
                default:
                begin
                    if (passes_reg)
                    begin
                        push.cnt = 2'd1;
                        push.item[0] = '{last_of_frame: is_last, byte_index: pos_reg,
                                         frame_byte: rx_byte};
                    end
                    if (is_last)
                    begin
                        pos_next    = hlfd_pkg::POS_HUNT;
                        passes_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= hlfd_pkg::POS_HUNT;
            len_reg    <= '0;
            passes_reg <= 1'b0;
            hdr_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            passes_reg <= passes_next;
            hdr_reg    <= hdr_next;
        end
    end

    // three results only on the id byte
    a_triple_on_id: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd3) |-> (pos_reg == hlfd_pkg::POS_ID))
        else $error("three results outside the id byte");

    // position never runs past the longest frame
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= hlfd_pkg::POS_MAX)
        else $error("frame position out of range");

    // a last mark closes the frame
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd1 && push.item[0].last_of_frame)
        |=> (pos_reg == hlfd_pkg::POS_HUNT && !passes_reg))
        else $error("frame not closed after last byte");

endmodule

// ----- hdl/hlfd_out_fifo.sv -----
// output queue: takes up to three results per cycle, gives one per transfer
// depends on hlfd_pkg; DEPTH must be a power of two no smaller than eight

module hlfd_out_fifo
#(
    parameter int DEPTH = hlfd_pkg::OUT_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hlfd_pkg::hlfd_push_t push,
    input  logic                 stage_busy,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hlfd_pkg::hlfd_res_t  out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] PUSH_MAX = (CW + 1)'(hlfd_pkg::MAX_PUSH);
    localparam logic [CW:0] DEPTH_W  = (CW + 1)'(DEPTH);

    hlfd_pkg::hlfd_res_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [CW:0]   need;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    // room for the item in the stage plus one more worst-case item
    assign need = {1'b0, count_reg} + PUSH_MAX + (stage_busy ? PUSH_MAX : '0);
    assign room = (need <= DEPTH_W);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write, one slot per result
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < hlfd_pkg::MAX_PUSH; k++)
        begin
            if (2'(k) < push.cnt)
            begin
                mem[wr_ptr_reg + AW'(k)] <= push.item[k];
            end
        end
    end

    // occupancy never exceeds depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (CW + 1)'(push.cnt)) <= DEPTH_W)
        else $error("output queue overflow");

    // count follows pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) + CW'($past(push.cnt)) - CW'($past(pop))))
        else $error("output queue count mismatch");

    // pointers differ by the count
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == AW'(count_reg))
        else $error("output queue pointers disagree with count");

endmodule

// ----- hdl/header_length_frame_deframer_core.sv -----
// top level: input stage, configuration registers, parser and output queue; uses hlfd_pkg
// bytes are taken one per cycle while s_tready is high; each is registered in the input stage,
// and its results then go to the queue for m_*; the id byte writes three, others one at most
// s_tready follows queue room and a busy stage; at default depth only m_tready stalls drop it
// reset: asynchronous, active low; clears frame state, queue and stage, and loads
// header 0x8D, wanted id 0x25, filtering on

module header_length_frame_deframer_core
#(
    parameter int OUT_DEPTH = hlfd_pkg::OUT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] frame_byte, [16:8] byte_index, [23:17] zero
    output logic        m_tlast     // last_of_frame
);

    hlfd_pkg::hlfd_cfg_t  cfg_reg, cfg_next;
    hlfd_pkg::hlfd_push_t push;
    hlfd_pkg::hlfd_res_t  out_data;
    logic                 stage_valid_reg;
    logic [7:0]           stage_byte_reg;
    logic                 room;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                hlfd_pkg::REG_HEADER_VALUE:  cfg_next.header_value      = cfg_data;
                hlfd_pkg::REG_WANTED_ID:     cfg_next.wanted_message_id = cfg_data;
                hlfd_pkg::REG_FILTER_ENABLE: cfg_next.filter_enable     = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value      <= hlfd_pkg::HEADER_VALUE_RST;
            cfg_reg.wanted_message_id <= hlfd_pkg::WANTED_ID_RST;
            cfg_reg.filter_enable     <= hlfd_pkg::FILTER_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input stage register
    assign s_tready = room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stage_byte_reg <= s_tdata;
        end
    end

    // frame parser
    hlfd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stage_valid_reg),
        .rx_byte    (stage_byte_reg),
        .cfg        (cfg_reg),
        .push       (push)
    );

    // output queue
    hlfd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .stage_busy (stage_valid_reg),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // output packing
    assign m_tdata = {7'd0, out_data.byte_index, out_data.frame_byte};
    assign m_tlast = out_data.last_of_frame;

endmodule

// ----- verif/tb.sv -----
// testbench for header_length_frame_deframer_core: directed and random byte streams of frames, noise
// and broken frames; results checked against a built-in deframer model
// depends on hlfd_pkg and the core module only

module tb;

    localparam logic [1:0]  REG_UNUSED      = 2'd3;
    localparam int unsigned RANDOM_ITEMS    = 380;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT     = 800000;
    localparam int unsigned DRAIN_CYCLES    = 4;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = hlfd_pkg::REG_HEADER_VALUE;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [7:0] frame_byte, [16:8] byte_index, [23:17] zero
    logic        m_tlast;             // last_of_frame

    // stimulus and expectation stores
    logic [7:0]          pending_bytes[$];
    hlfd_pkg::hlfd_res_t expected_bytes[$];

    // deframer model: settings and frame state
    logic [7:0]  hdr_reg    = hlfd_pkg::HEADER_VALUE_RST;
    logic [7:0]  wanted_reg = hlfd_pkg::WANTED_ID_RST;
    logic        filter_on  = hlfd_pkg::FILTER_ENABLE_RST;
    logic [8:0]  frame_pos  = hlfd_pkg::POS_HUNT;
    logic [7:0]  frame_len  = 8'h00;
    logic [7:0]  frame_hdr  = 8'h00;
    logic        frame_on   = 1'b0;

    logic        s_fire      = 1'b0;
    int unsigned send_gap    = 0;
    int unsigned send_quiet  = 0;
    int unsigned ready_stall = 0;
    int unsigned ready_quiet = 0;
    logic        held_off    = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned random_count = 0;
    int unsigned phase_num   = 0;

    header_length_frame_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    // occasional runs of back-to-back transfers
    function automatic int unsigned next_quiet(input int unsigned q);
        if (q != 0)
            return q - 1;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : 0;
    endfunction

    function automatic hlfd_pkg::hlfd_res_t res_of(input logic [7:0] b,
                                                   input logic [8:0] idx,
                                                   input logic last);
        hlfd_pkg::hlfd_res_t r;
        r.frame_byte    = b;
        r.byte_index    = idx;
        r.last_of_frame = last;
        return r;
    endfunction

    // advance the deframer model by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [8:0] last_pos;
        last_pos = {1'b0, frame_len} + hlfd_pkg::FRAME_OVERHEAD_M1;
        if (frame_pos == hlfd_pkg::POS_HUNT) begin
            if (b == hdr_reg) begin
                frame_hdr = b;
                frame_pos = hlfd_pkg::POS_LENGTH;
            end
        end else if (frame_pos == hlfd_pkg::POS_LENGTH) begin
            frame_len = b;
            frame_pos = hlfd_pkg::POS_ID;
        end else if (frame_pos == hlfd_pkg::POS_ID) begin
            // pass decision is taken here and kept to the end of the frame
            frame_on = !filter_on || (b == wanted_reg);
            if (frame_on) begin
                expected_bytes = {expected_bytes,
                                  res_of(frame_hdr, hlfd_pkg::POS_HUNT, 1'b0)};
                expected_bytes = {expected_bytes,
                                  res_of(frame_len, hlfd_pkg::POS_LENGTH, 1'b0)};
                expected_bytes = {expected_bytes,
                                  res_of(b, hlfd_pkg::POS_ID, 1'b0)};
            end
            frame_pos = hlfd_pkg::POS_ID + 9'd1;
        end else begin
            if (frame_on)
                expected_bytes = {expected_bytes,
                                  res_of(b, frame_pos, frame_pos >= last_pos)};
            if (frame_pos >= last_pos) begin
                frame_pos = hlfd_pkg::POS_HUNT;
                frame_on  = 1'b0;
            end else begin
                frame_pos = frame_pos + 9'd1;
            end
        end
    endtask

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // transfer still pending, hold
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
            s_tdata    <= pending_bytes.pop_front();
            s_tvalid   <= 1'b1;
            send_gap   <= (send_quiet != 0) ? 0 : gap_length();
            send_quiet <= next_quiet(send_quiet);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // output ready, with one long hold-off while input is still queued
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (ready_stall != 0) begin
            ready_stall <= ready_stall - 1;
            m_tready    <= 1'b0;
        end else if (!held_off && pending_bytes.size() > 20) begin
            held_off    <= 1'b1;
            ready_stall <= HOLD_OFF_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready    <= 1'b1;
            ready_stall <= (ready_quiet != 0) ? 0 : gap_length();
            ready_quiet <= next_quiet(ready_quiet);
        end
    end

    // monitor: register writes, input transfers into the model, output checks
    always @(posedge clk) begin
        hlfd_pkg::hlfd_res_t got;
        hlfd_pkg::hlfd_res_t want;
        s_fire <= s_tvalid && s_tready;
        if (cfg_we) begin
            case (cfg_addr)
                hlfd_pkg::REG_HEADER_VALUE:  hdr_reg    = cfg_data;
                hlfd_pkg::REG_WANTED_ID:     wanted_reg = cfg_data;
                hlfd_pkg::REG_FILTER_ENABLE: filter_on  = cfg_data[0];
                default: ;
            endcase
        end
        if (s_tvalid && s_tready)
            deframe_byte(s_tdata);
        if (m_tvalid && m_tready) begin
            got = res_of(m_tdata[7:0], m_tdata[16:8], m_tlast);
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected transfer: byte %h index %0d last %b",
                         $time, got.frame_byte, got.byte_index, got.last_of_frame);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (got.frame_byte !== want.frame_byte) begin
                    $display("%0t: frame_byte expected %h actual %h",
                             $time, want.frame_byte, got.frame_byte);
                    fail_count++;
                end
                if (got.byte_index !== want.byte_index) begin
                    $display("%0t: byte_index expected %0d actual %0d",
                             $time, want.byte_index, got.byte_index);
                    fail_count++;
                end
                if (got.last_of_frame !== want.last_of_frame) begin
                    $display("%0t: last_of_frame expected %b actual %b",
                             $time, want.last_of_frame, got.last_of_frame);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // all input taken, all results out, pipeline empty
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input logic [7:0] hdr, input int unsigned len,
                               input logic [7:0] id);
        pending_bytes = {pending_bytes, hdr};
        pending_bytes = {pending_bytes, 8'(len)};
        pending_bytes = {pending_bytes, id};
        repeat (len + 1) pending_bytes = {pending_bytes, 8'($urandom)};
    endtask

    // mostly well-formed frames, some noise and some cut-short frames
    task automatic queue_random_phase(input int unsigned n);
        int unsigned added;
        int unsigned r;
        int unsigned len;
        added = 0;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                queue_frame(hdr_reg, len,
                            ($urandom_range(0, 99) < 65) ? wanted_reg : 8'($urandom));
                added += len + 4;
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    pending_bytes = {pending_bytes, 8'($urandom)};
                    added++;
                end
            end else begin
                // header and up to two bytes; whatever follows becomes its body
                pending_bytes = {pending_bytes, hdr_reg};
                added++;
                repeat ($urandom_range(0, 2)) begin
                    pending_bytes = {pending_bytes, 8'($urandom)};
                    added++;
                end
            end
        end
        random_count += added;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: noise, zero-length frame, rejected id, header value as data,
        // then a frame left open after its header
        pending_bytes = {8'h00, 8'hFF,
                         8'h8D, 8'h00, 8'h25, 8'hFF,
                         8'h8D, 8'h01, 8'h24, 8'h8D, 8'h00,
                         8'h8D, 8'h02, 8'h25, 8'h8D, 8'h00, 8'hFF,
                         8'h8D};
        wait_idle();

        // header register changes inside the open frame; received header goes out
        write_reg(hlfd_pkg::REG_HEADER_VALUE, 8'h5A);
        pending_bytes = {8'h01, 8'h25, 8'hAA, 8'h55};
        wait_idle();

        // filtering off, index out of range ignored
        write_reg(hlfd_pkg::REG_FILTER_ENABLE, 8'hFE);
        write_reg(hlfd_pkg::REG_WANTED_ID, 8'h00);
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(hlfd_pkg::REG_HEADER_VALUE, 8'h00);
        pending_bytes = {8'h00, 8'h00, 8'hFF, 8'h00};

        // random phases, each with new settings
        while (random_count < RANDOM_ITEMS) begin
            wait_idle();
            write_reg(hlfd_pkg::REG_HEADER_VALUE, pick_byte());
            write_reg(hlfd_pkg::REG_WANTED_ID, pick_byte());
            write_reg(hlfd_pkg::REG_FILTER_ENABLE, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 8'($urandom));
            // one frame of the longest length
            if (phase_num == 2) begin
                queue_frame(hdr_reg, 255, wanted_reg);
                random_count += 255 + 4;
            end
            queue_random_phase($urandom_range(30, 60));
            phase_num++;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- header_length_frame_deframer_core.f -----
hdl/hlfd_pkg.sv
hdl/hlfd_parser.sv
hdl/hlfd_out_fifo.sv
hdl/header_length_frame_deframer_core.sv
verif/tb.sv
